@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ sv/aes_pkg.sv @@
package aes_pkg;
	localparam int Rounds = 10;
	localparam int KeyWords = 4 * (Rounds + 1);
	localparam int KwIdxW = $clog2(KeyWords);
	localparam logic [0:0] CfgKeyHigh = 1'b0;
	localparam logic [0:0] CfgKeyLow = 1'b1;

	typedef logic [127:0] blk_t;

	typedef struct packed {
		logic valid;
		logic dec;
	} ctl_t;

	localparam logic [7:0] FwdBox [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RevBox [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte n of the block sits in bits 127-8n .. 120-8n.
	function automatic logic [7:0] get_byte(input blk_t s, input int n);
		return s[127 - 8 * n -: 8];
	endfunction

	function automatic blk_t sub_shift(input blk_t s, input logic inv);
		blk_t o;
		int src;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
				o[127 - 8 * (r + 4 * c) -: 8] = inv ? RevBox[get_byte(s, r + 4 * src)]
					: FwdBox[get_byte(s, r + 4 * src)];
			end
		end
		return o;
	endfunction

	function automatic blk_t mix(input blk_t s, input logic inv);
		blk_t o;
		logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4 * c);
			a1 = get_byte(s, 4 * c + 1);
			a2 = get_byte(s, 4 * c + 2);
			a3 = get_byte(s, 4 * c + 3);
			x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
			y0 = xt(x0); y1 = xt(x1); y2 = xt(x2); y3 = xt(x3);
			z0 = xt(y0); z1 = xt(y1); z2 = xt(y2); z3 = xt(y3);
			if (!inv) begin
				o[127 - 32 * c -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
				o[119 - 32 * c -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
				o[111 - 32 * c -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
				o[103 - 32 * c -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
			end else begin
				// 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1.
				o[127 - 32 * c -: 8] = (z0 ^ y0 ^ x0) ^ (z1 ^ x1 ^ a1) ^ (z2 ^ y2 ^ a2)
					^ (z3 ^ a3);
				o[119 - 32 * c -: 8] = (z0 ^ a0) ^ (z1 ^ y1 ^ x1) ^ (z2 ^ x2 ^ a2)
					^ (z3 ^ y3 ^ a3);
				o[111 - 32 * c -: 8] = (z0 ^ y0 ^ a0) ^ (z1 ^ a1) ^ (z2 ^ y2 ^ x2)
					^ (z3 ^ x3 ^ a3);
				o[103 - 32 * c -: 8] = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1) ^ (z2 ^ a2)
					^ (z3 ^ y3 ^ x3);
			end
		end
		return o;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
	endfunction
endpackage

@@ sv/aes_key_sched.sv @@
// Key expansion: one word per cycle into the round-key registers.
`include "assert_macros.svh"
module aes_key_sched import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         kick,
	input  logic [127:0] key,
	output logic         ready,
	output logic         busy,
	output blk_t         rkeys [Rounds + 1]
);
	logic [31:0]       words_q [KeyWords];
	logic [31:0]       win_q [4];
	logic [KwIdxW-1:0] idx_q;
	logic [7:0]        rc_q;
	logic              run_q;
	logic              ready_q;
	logic [31:0]       t;
	logic [31:0]       nxt;

	// The last four words are kept in a small window so that the next word
	// never needs a read of the round-key registers at a moving address.
	always_comb begin
		t = win_q[3];
		if (idx_q[1:0] == 2'b00) begin
			t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
		end
		nxt = win_q[0] ^ t;
	end

	always_ff @(posedge clk) begin
		if (kick) begin
			words_q[0] <= key[127:96];
			words_q[1] <= key[95:64];
			words_q[2] <= key[63:32];
			words_q[3] <= key[31:0];
			win_q[0]   <= key[127:96];
			win_q[1]   <= key[95:64];
			win_q[2]   <= key[63:32];
			win_q[3]   <= key[31:0];
		end else if (run_q) begin
			words_q[idx_q] <= nxt;
			win_q[0]       <= win_q[1];
			win_q[1]       <= win_q[2];
			win_q[2]       <= win_q[3];
			win_q[3]       <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rc_q    <= 8'h01;
			run_q   <= 1'b0;
			ready_q <= 1'b0;
		end else if (kick) begin
			idx_q   <= KwIdxW'(4);
			rc_q    <= 8'h01;
			run_q   <= 1'b1;
			ready_q <= 1'b0;
		end else if (run_q) begin
			if (idx_q[1:0] == 2'b00) begin
				rc_q <= xt(rc_q);
			end
			if (idx_q == KwIdxW'(KeyWords - 1)) begin
				run_q   <= 1'b0;
				ready_q <= 1'b1;
			end
			idx_q <= idx_q + KwIdxW'(1);
		end
	end

	for (genvar r = 0; r <= Rounds; r++) begin : g_rk
		assign rkeys[r] = {words_q[4 * r], words_q[4 * r + 1], words_q[4 * r + 2],
			words_q[4 * r + 3]};
	end

	assign ready = ready_q;
	assign busy  = run_q;

	`ASSERT_IMPLIES(a_not_both, clk, arst_n, 1'b1, !(run_q && ready_q))
	`ASSERT_NEXT(a_kick_runs, clk, arst_n, kick, run_q && idx_q == KwIdxW'(4))
	`ASSERT_IMPLIES(a_idx_range, clk, arst_n, run_q, idx_q >= KwIdxW'(4))
endmodule

@@ sv/aes_round.sv @@
// One cipher round stage, forward or inverse, registered at its output.
module aes_round import aes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl_in,
	input  blk_t state_in,
	input  blk_t key_enc,
	input  blk_t key_dec,
	input  logic last,
	output ctl_t ctl_out,
	output blk_t state_out
);
	blk_t ss;
	blk_t nxt;
	blk_t state_s1;
	ctl_t ctl_s1;

	always_comb begin
		ss = sub_shift(state_in, ctl_in.dec);
		if (!ctl_in.dec) begin
			nxt = (last ? ss : mix(ss, 1'b0)) ^ key_enc;
		end else begin
			nxt = last ? (ss ^ key_dec) : mix(ss ^ key_dec, 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		state_s1 <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	assign ctl_out   = ctl_s1;
	assign state_out = state_s1;
endmodule

@@ sv/aes128_block_cipher_unit.sv @@
// AES-128 ECB engine. A block is taken each cycle that start is high and
// busy low; its result appears on result_high/result_low with done high for
// one cycle, after an input key-add stage and ten round stages, and cannot
// be held off. After reset or a key write the key schedule is rebuilt on the
// next start, with busy high while it runs; the block that triggered it is
// taken only if start is still high once busy falls.
`include "assert_macros.svh"
module aes128_block_cipher_unit import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic        stale_q;
	logic        sched_ready;
	logic        sched_busy;
	logic        kick;
	logic        accept;
	blk_t        rkeys [Rounds + 1];
	blk_t        st [Rounds + 1];
	ctl_t        ctl [Rounds + 1];
	blk_t        in_s1;
	ctl_t        in_ctl_s1;

	assign cfg_ready = 1'b1;
	assign kick   = start && (stale_q || !sched_ready) && !sched_busy;
	assign busy   = stale_q || !sched_ready;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			stale_q    <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CfgKeyHigh: key_high_q <= cfg_data;
					CfgKeyLow:  key_low_q  <= cfg_data;
					default: ;
				endcase
				stale_q <= 1'b1;
			end else if (kick) begin
				stale_q <= 1'b0;
			end
		end
	end

	aes_key_sched u_sched (
		.clk(clk), .arst_n(arst_n), .kick(kick), .key({key_high_q, key_low_q}),
		.ready(sched_ready), .busy(sched_busy), .rkeys(rkeys)
	);

	always_ff @(posedge clk) begin
		in_s1 <= {block_high, block_low} ^ (kind ? rkeys[Rounds] : rkeys[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ctl_s1 <= '0;
		end else begin
			in_ctl_s1 <= '{valid: accept, dec: kind};
		end
	end

	assign st[0]  = in_s1;
	assign ctl[0] = in_ctl_s1;

	for (genvar r = 1; r <= Rounds; r++) begin : g_round
		aes_round u_round (
			.clk(clk), .arst_n(arst_n), .ctl_in(ctl[r - 1]), .state_in(st[r - 1]),
			.key_enc(rkeys[r]), .key_dec(rkeys[Rounds - r]), .last(r == Rounds),
			.ctl_out(ctl[r]), .state_out(st[r])
		);
	end

	assign done        = ctl[Rounds].valid;
	assign result_high = st[Rounds][127:64];
	assign result_low  = st[Rounds][63:0];

	`ASSERT_IMPLIES(a_accept_ready, clk, arst_n, accept, sched_ready && !stale_q)
	`ASSERT_NEXT(a_kick_busy, clk, arst_n, kick, busy)
	`ASSERT_NEXT(a_in_valid, clk, arst_n, accept, in_ctl_s1.valid)
endmodule
